// ===== rtl/kfa_pkg.sv =====
`default_nettype none
package kfa_pkg;

  typedef struct packed {
    logic [1:0]         axis;
    logic signed [31:0] measured_angle;
    logic signed [31:0] rate;
  } in_t;

  typedef struct packed {
    logic [1:0]         axis_out;
    logic signed [31:0] angle_estimate;
  } out_t;

  typedef enum logic [1:0] {
    CFG_LOOP_PERIOD   = 2'd0,
    CFG_ANGLE_NOISE   = 2'd1,
    CFG_BIAS_NOISE    = 2'd2,
    CFG_MEASURE_NOISE = 2'd3
  } cfg_idx_t;

  localparam int CFG_W = 31;
  localparam logic [CFG_W-1:0] RST_LOOP_PERIOD   = 31'd21474836;
  localparam logic [CFG_W-1:0] RST_ANGLE_NOISE   = 31'd10737418;
  localparam logic [CFG_W-1:0] RST_BIAS_NOISE    = 31'd322123;
  localparam logic [CFG_W-1:0] RST_MEASURE_NOISE = 31'd10737418;

  localparam logic signed [39:0] MAX40 = 40'sd2147483647;
  localparam logic signed [39:0] MIN40 = -40'sd2147483648;

  // Q2.30 product back to working scale, round half away from zero
  function automatic logic signed [37:0] rnd30(input logic signed [67:0] v);
    logic [67:0] mag;
    logic [67:0] r;
    logic [37:0] rm;
    mag = v[67] ? 68'(-v) : 68'(v);
    r   = (mag + 68'(1 << 29)) >> 30;
    rm  = r[37:0];
    return v[67] ? -$signed(rm) : $signed(rm);
  endfunction

  function automatic logic [31:0] sat32(input logic signed [39:0] v);
    logic [31:0] r;
    if (v > MAX40) r = 32'h7fff_ffff;
    else if (v < MIN40) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/kfa_div.sv =====
`default_nettype none
module kfa_div (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [31:0] num0,
  input  wire logic signed [31:0] num1,
  input  wire logic [32:0]        den,
  output logic                    done,
  output logic signed [31:0]      q0,
  output logic signed [31:0]      q1
);
  import kfa_pkg::*;

  // quotient = (num << 30) / den, two lanes sharing the divisor, one bit a cycle
  localparam int QB = 33;

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [33:0] rem_r [2];
  logic [32:0] sh_r  [2];
  logic [32:0] q_r   [2];
  logic        ovf_r [2];
  logic        neg_r [2];
  logic signed [31:0] res [2];
  logic [31:0] mag [2];
  logic [33:0] trial [2];
  logic signed [31:0] nums [2];

  assign nums[0] = num0;
  assign nums[1] = num1;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 6'(QB);
    end else if (busy_r) begin
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      mag[i]   = nums[i][31] ? 32'(-nums[i]) : 32'(nums[i]);
      trial[i] = {rem_r[i][32:0], sh_r[i][32]};
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 2; i++) begin
      if (start) begin
        rem_r[i] <= 34'(mag[i] >> 3);
        sh_r[i]  <= {mag[i][2:0], 30'd0};
        q_r[i]   <= '0;
        ovf_r[i] <= ({4'b0, mag[i]} >= ({3'b0, den} << 3));
        neg_r[i] <= nums[i][31];
      end else if (busy_r) begin
        sh_r[i] <= sh_r[i] << 1;
        if (trial[i] >= {1'b0, den}) begin
          rem_r[i] <= trial[i] - {1'b0, den};
          q_r[i]   <= {q_r[i][31:0], 1'b1};
        end else begin
          rem_r[i] <= trial[i];
          q_r[i]   <= {q_r[i][31:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      if (neg_r[i]) begin
        if (ovf_r[i] || q_r[i] > 33'h0_8000_0000) res[i] = 32'sh8000_0000;
        else res[i] = 32'(-q_r[i]);
      end else begin
        if (ovf_r[i] || q_r[i] > 33'h0_7fff_ffff) res[i] = 32'sh7fff_ffff;
        else res[i] = q_r[i][31:0];
      end
    end
  end

  assign done = done_r;
  assign q0   = res[0];
  assign q1   = res[1];

endmodule
`default_nettype wire

// ===== rtl/imu_angle_kalman_filter.sv =====
`default_nettype none
// Two-state (angle, gyro bias) Kalman filter, one filter per axis, Q16.16 angles and
// Q2.30 covariances with saturation. One shared 34x34 multiplier runs the predict and
// update products and a two-lane bit-serial divider forms both gains. The result beat
// is offered after the predict products, a prepare step, the divide (33 quotient bits
// and the handoff) and the update products; a new item is taken only after the beat
// is taken. When the innovation variance is not positive the divide is skipped.
// An axis outside the configured count returns angle 0.
// in_ready is low from accept until the result beat is taken.
module imu_angle_kalman_filter #(
  parameter int AXES = 3
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire kfa_pkg::in_t    in_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output kfa_pkg::out_t        out_data,
  input  wire logic            cfg_we,
  input  wire logic [1:0]      cfg_index,
  input  wire logic [30:0]     cfg_wdata
);
  import kfa_pkg::*;

  localparam int IDXW = (AXES > 1) ? $clog2(AXES) : 1;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_PREP = 5'b00100,
    S_DIV  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_ANG, OP_P00A, OP_P00B, OP_P01, OP_P11,
    OP_UANG, OP_UBIAS, OP_U00, OP_U01, OP_U10, OP_U11
  } op_t;

  state_t state_r, state_nxt;
  op_t    iss_r, iss_nxt, cons_r;

  logic [CFG_W-1:0] dt_r, qa_r, qb_r, rn_r;

  logic [31:0] ang_a [AXES];
  logic [31:0] bias_a [AXES];
  logic [31:0] c00_a [AXES];
  logic [31:0] c01_a [AXES];
  logic [31:0] c10_a [AXES];
  logic [31:0] c11_a [AXES];

  logic [IDXW-1:0] idx_r;
  logic [1:0]      ax_r;
  logic signed [31:0] meas_r, rate_r, ang_r, bias_r, p00_r, p01_r, p10_r, p11_r;
  logic signed [31:0] k0_r, k1_r;
  logic signed [32:0] y_r;
  logic signed [39:0] acc_r;
  logic signed [67:0] prod_r;
  logic signed [33:0] ma, mb;
  logic signed [37:0] r;
  logic signed [33:0] s;
  logic [4:0]      ax5;
  logic            ax_ok;
  logic            out_valid_r;
  out_t            out_r;
  logic            div_start, div_done;
  logic signed [31:0] dq0, dq1;

  function automatic logic signed [33:0] sx(input logic [31:0] x);
    return $signed({{2{x[31]}}, x});
  endfunction

  function automatic logic signed [33:0] ux(input logic [CFG_W-1:0] x);
    return $signed({3'b0, x});
  endfunction

  function automatic logic signed [39:0] sx40(input logic [31:0] x);
    return $signed({{8{x[31]}}, x});
  endfunction

  assign ax5   = {3'b0, in_data.axis};
  assign ax_ok = ax5 < 5'(AXES);
  assign r     = rnd30(prod_r);
  assign s     = sx(p00_r) + ux(rn_r);

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dt_r <= RST_LOOP_PERIOD;
      qa_r <= RST_ANGLE_NOISE;
      qb_r <= RST_BIAS_NOISE;
      rn_r <= RST_MEASURE_NOISE;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_LOOP_PERIOD:   dt_r <= cfg_wdata;
        CFG_ANGLE_NOISE:   qa_r <= cfg_wdata;
        CFG_BIAS_NOISE:    qb_r <= cfg_wdata;
        CFG_MEASURE_NOISE: rn_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // shared multiplier operands
  always_comb begin
    ma = '0;
    mb = '0;
    case (iss_r)
      OP_ANG: begin
        ma = ux(dt_r);
        mb = sx(rate_r) - sx(bias_r);
      end
      OP_P00A: begin
        ma = ux(dt_r);
        mb = sx(p01_r) + sx(p10_r);
      end
      OP_P00B: begin
        ma = ux(qa_r);
        mb = ux(dt_r);
      end
      OP_P01: begin
        ma = ux(dt_r);
        mb = sx(p11_r);
      end
      OP_P11: begin
        ma = ux(qb_r);
        mb = ux(dt_r);
      end
      OP_UANG: begin
        ma = sx(k0_r);
        mb = {y_r[32], y_r};
      end
      OP_UBIAS: begin
        ma = sx(k1_r);
        mb = {y_r[32], y_r};
      end
      OP_U00: begin
        ma = sx(k0_r);
        mb = sx(p00_r);
      end
      OP_U01: begin
        ma = sx(k0_r);
        mb = sx(p01_r);
      end
      OP_U10: begin
        ma = sx(k1_r);
        mb = sx(p00_r);
      end
      OP_U11: begin
        ma = sx(k1_r);
        mb = sx(p01_r);
      end
      default: ;
    endcase
  end

  always_comb begin
    case (iss_r)
      OP_ANG:   iss_nxt = OP_P00A;
      OP_P00A:  iss_nxt = OP_P00B;
      OP_P00B:  iss_nxt = OP_P01;
      OP_P01:   iss_nxt = OP_P11;
      OP_UANG:  iss_nxt = OP_UBIAS;
      OP_UBIAS: iss_nxt = OP_U00;
      OP_U00:   iss_nxt = OP_U01;
      OP_U01:   iss_nxt = OP_U10;
      OP_U10:   iss_nxt = OP_U11;
      default:  iss_nxt = OP_NONE;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = ax_ok ? S_MUL : S_DONE;
      S_MUL: begin
        if (cons_r == OP_P11) state_nxt = S_PREP;
        else if (cons_r == OP_U11) state_nxt = S_DONE;
      end
      S_PREP: state_nxt = (!s[33] && s != '0) ? S_DIV : S_MUL;
      S_DIV:  if (div_done) state_nxt = S_MUL;
      S_DONE: if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign div_start = (state_r == S_PREP) && !s[33] && (s != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      iss_r       <= OP_NONE;
      cons_r      <= OP_NONE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < AXES; i++) begin
        ang_a[i]  <= '0;
        bias_a[i] <= '0;
        c00_a[i]  <= '0;
        c01_a[i]  <= '0;
        c10_a[i]  <= '0;
        c11_a[i]  <= '0;
      end
    end else begin
      state_r <= state_nxt;
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            if (ax_ok) begin
              iss_r <= OP_ANG;
            end else begin
              out_valid_r <= 1'b1;
            end
          end
        end
        S_MUL: begin
          iss_r  <= iss_nxt;
          cons_r <= iss_r;
          case (cons_r)
            OP_UANG:  ang_a[idx_r]  <= sat32(sx40(ang_r) + 40'(r));
            OP_UBIAS: bias_a[idx_r] <= sat32(sx40(bias_r) + 40'(r));
            OP_U00:   c00_a[idx_r]  <= sat32(sx40(p00_r) - 40'(r));
            OP_U01:   c01_a[idx_r]  <= sat32(sx40(p01_r) - 40'(r));
            OP_U10:   c10_a[idx_r]  <= sat32(sx40(p10_r) - 40'(r));
            OP_U11: begin
              c11_a[idx_r] <= sat32(sx40(p11_r) - 40'(r));
              out_valid_r  <= 1'b1;
            end
            default: ;
          endcase
        end
        S_PREP: begin
          iss_r <= div_start ? OP_NONE : OP_UANG;
        end
        S_DIV: begin
          if (div_done) iss_r <= OP_UANG;
        end
        S_DONE: if (out_ready) out_valid_r <= 1'b0;
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    prod_r <= ma * mb;
    case (state_r)
      S_IDLE: begin
        idx_r  <= ax5[IDXW-1:0];
        ax_r   <= in_data.axis;
        meas_r <= in_data.measured_angle;
        rate_r <= in_data.rate;
        if (ax_ok) begin
          ang_r  <= ang_a[ax5[IDXW-1:0]];
          bias_r <= bias_a[ax5[IDXW-1:0]];
          p00_r  <= c00_a[ax5[IDXW-1:0]];
          p01_r  <= c01_a[ax5[IDXW-1:0]];
          p10_r  <= c10_a[ax5[IDXW-1:0]];
          p11_r  <= c11_a[ax5[IDXW-1:0]];
        end
        out_r.axis_out       <= in_data.axis;
        out_r.angle_estimate <= '0;
      end
      S_MUL: begin
        case (cons_r)
          OP_ANG:  ang_r <= sat32(sx40(ang_r) + 40'(r));
          OP_P00A: acc_r <= sx40(p00_r) - 40'(r);
          OP_P00B: p00_r <= sat32(acc_r + 40'(r));
          OP_P01: begin
            p01_r <= sat32(sx40(p01_r) - 40'(r));
            p10_r <= sat32(sx40(p10_r) - 40'(r));
          end
          OP_P11:  p11_r <= sat32(sx40(p11_r) + 40'(r));
          OP_UANG: begin
            out_r.axis_out       <= ax_r;
            out_r.angle_estimate <= sat32(sx40(ang_r) + 40'(r));
          end
          default: ;
        endcase
      end
      S_PREP: begin
        y_r  <= $signed({meas_r[31], meas_r}) - $signed({ang_r[31], ang_r});
        k0_r <= '0;
        k1_r <= '0;
      end
      S_DIV: begin
        if (div_done) begin
          k0_r <= dq0;
          k1_r <= dq1;
        end
      end
      default: ;
    endcase
  end

  kfa_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num0  (p00_r),
    .num1  (p10_r),
    .den   (s[32:0]),
    .done  (div_done),
    .q0    (dq0),
    .q1    (dq1)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire
